FILE: design/cbor_stream_decoder_macros.svh
// Assertion helpers for the CBOR stream decoder.
`ifndef CBOR_STREAM_DECODER_MACROS_SVH
`define CBOR_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/cbor_sd_pkg.sv
package cbor_sd_pkg;

   // additional info codes
   localparam logic [4:0] INFO_DIRECT_MAX = 5'd23;
   localparam logic [4:0] INFO_1B         = 5'd24;
   localparam logic [4:0] INFO_2B         = 5'd25;
   localparam logic [4:0] INFO_4B         = 5'd26;
   localparam logic [4:0] INFO_8B         = 5'd27;
   localparam logic [4:0] SIMPLE_FALSE    = 5'd20;
   localparam logic [4:0] SIMPLE_TRUE     = 5'd21;
   localparam logic [4:0] SIMPLE_NULL     = 5'd22;

   // major types
   localparam logic [2:0] MAJ_UINT   = 3'd0;
   localparam logic [2:0] MAJ_NEGINT = 3'd1;
   localparam logic [2:0] MAJ_BYTES  = 3'd2;
   localparam logic [2:0] MAJ_TEXT   = 3'd3;
   localparam logic [2:0] MAJ_ARRAY  = 3'd4;
   localparam logic [2:0] MAJ_MAP    = 3'd5;
   localparam logic [2:0] MAJ_TAG    = 3'd6;
   localparam logic [2:0] MAJ_SIMPLE = 3'd7;

   // token kinds
   localparam logic [3:0] KIND_UINT    = 4'd0;
   localparam logic [3:0] KIND_NEGINT  = 4'd1;
   localparam logic [3:0] KIND_FALSE   = 4'd6;
   localparam logic [3:0] KIND_PAYLOAD = 4'd9;
   localparam logic [3:0] KIND_ERROR   = 4'd10;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_RESERVED = 3'd1;
   localparam logic [2:0] ERR_TAG      = 3'd2;
   localparam logic [2:0] ERR_SIMPLE   = 3'd3;
   localparam logic [2:0] ERR_HEAD_CUT = 3'd4;
   localparam logic [2:0] ERR_STR_CUT  = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [3:0]         token_kind;
      logic [63:0]        argument;
      logic signed [63:0] signed_value;
      logic               fits_signed;
      logic [7:0]         payload_byte;
      logic               payload_last;
      logic [2:0]         error_code;
      logic               at_message_end;
   } rsp_type;

   // classified byte handed from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_end;
      logic [2:0] major;
      logic [4:0] info;
      logic       reserved;
      logic       direct;
      logic       simple_ok;
      logic [3:0] simple_kind;
      logic [3:0] arg_len;
   } cls_type;

   // back-end handshake status
   typedef struct packed {
      logic take;
      logic wrote;
   } back_status_type;

   function automatic logic [3:0] arg_len_of(input logic [4:0] info);
      logic [3:0] len;
      begin
         unique case (info)
            INFO_1B: len = 4'd1;
            INFO_2B: len = 4'd2;
            INFO_4B: len = 4'd4;
            INFO_8B: len = 4'd8;
            default: len = 4'd0;
         endcase
         return len;
      end
   endfunction

endpackage

FILE: design/cbor_sd_front.sv
module cbor_sd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  cbor_sd_pkg::req_type         req_data,
   output logic                         mid_valid,
   output cbor_sd_pkg::cls_type         mid_word,
   input  cbor_sd_pkg::back_status_type back_status
);
   import cbor_sd_pkg::*;

   cls_type    mem_ff [2];
   cls_type    cls;
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic       push_ok;

   always_comb begin
      cls             = '0;
      cls.data_byte   = req_data.data_byte;
      cls.message_end = req_data.message_end;
      cls.major       = req_data.data_byte[7:5];
      cls.info        = req_data.data_byte[4:0];
      cls.reserved    = cls.info > INFO_8B;
      cls.direct      = cls.info <= INFO_DIRECT_MAX;
      cls.simple_ok   = (cls.info == SIMPLE_FALSE) || (cls.info == SIMPLE_TRUE)
                        || (cls.info == SIMPLE_NULL);
      cls.simple_kind = KIND_FALSE + 4'(cls.info - SIMPLE_FALSE);
      cls.arg_len     = arg_len_of(cls.info);
   end

   assign req_full  = count_ff == 2'd2;
   assign push_ok   = req_push && !req_full;
   assign mid_valid = count_ff != 2'd0;
   assign mid_word  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_ok && !back_status.take) begin
         count_in = count_ff + 2'd1;
      end else if (!push_ok && back_status.take) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push_ok) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (back_status.take) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

FILE: design/cbor_sd_back.sv
module cbor_sd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         mid_valid,
   input  cbor_sd_pkg::cls_type         mid_word,
   output cbor_sd_pkg::back_status_type back_status,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output cbor_sd_pkg::rsp_type         rsp_data
);
   import cbor_sd_pkg::*;

   typedef enum logic [3:0] {
      PH_INITIAL = 4'b0001,
      PH_ARG     = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_DISCARD = 4'b1000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  major_ff, major_in;
   logic [3:0]  left_ff, left_in, left_dec;
   logic [63:0] acc_ff, acc_in, acc_shift;
   logic [63:0] pay_ff, pay_in, pay_dec;

   rsp_type     mem_ff [2];
   rsp_type     res;
   logic [1:0]  count_ff, count_in;
   logic        wr_ptr_ff, rd_ptr_ff;
   logic        take, res_valid, wrote, pop_ok;

   logic        fin_go, fail_go;
   logic [2:0]  fin_major, fail_code;
   logic [63:0] fin_arg;

   assign take      = mid_valid && (count_ff != 2'd2);
   assign wrote     = take && res_valid;
   assign pop_ok    = rsp_pop && !rsp_empty;
   assign rsp_empty = count_ff == 2'd0;
   assign rsp_data  = mem_ff[rd_ptr_ff];

   assign back_status.take  = take;
   assign back_status.wrote = wrote;

   always_comb begin
      phase_in  = phase_ff;
      major_in  = major_ff;
      left_in   = left_ff;
      acc_in    = acc_ff;
      pay_in    = pay_ff;
      res       = '0;
      res.at_message_end = mid_word.message_end;
      res_valid = 1'b0;
      fin_go    = 1'b0;
      fin_major = mid_word.major;
      fin_arg   = {59'd0, mid_word.info};
      fail_go   = 1'b0;
      fail_code = ERR_NONE;
      acc_shift = {acc_ff[55:0], mid_word.data_byte};
      left_dec  = (left_ff != 4'd0) ? left_ff - 4'd1 : 4'd0;
      pay_dec   = pay_ff - 64'd1;

      if (take) begin
         unique case (phase_ff)
            PH_DISCARD: begin
               if (mid_word.message_end) begin
                  phase_in = PH_INITIAL;
               end
            end
            PH_PAYLOAD: begin
               pay_in = pay_dec;
               if (pay_dec != 64'd0 && mid_word.message_end) begin
                  pay_in    = '0;
                  fail_go   = 1'b1;
                  fail_code = ERR_STR_CUT;
               end else begin
                  res_valid        = 1'b1;
                  res.token_kind   = KIND_PAYLOAD;
                  res.payload_byte = mid_word.data_byte;
                  res.payload_last = pay_dec == 64'd0;
                  if (pay_dec == 64'd0 || mid_word.message_end) begin
                     phase_in = PH_INITIAL;
                  end
               end
            end
            PH_ARG: begin
               acc_in  = acc_shift;
               left_in = left_dec;
               if (left_dec == 4'd0) begin
                  fin_go    = 1'b1;
                  fin_major = major_ff;
                  fin_arg   = acc_shift;
               end else if (mid_word.message_end) begin
                  left_in   = '0;
                  fail_go   = 1'b1;
                  fail_code = ERR_HEAD_CUT;
               end
            end
            PH_INITIAL: begin
               priority if (mid_word.reserved) begin
                  fail_go   = 1'b1;
                  fail_code = ERR_RESERVED;
               end else if (mid_word.major == MAJ_TAG) begin
                  fail_go   = 1'b1;
                  fail_code = ERR_TAG;
               end else if (mid_word.major == MAJ_SIMPLE) begin
                  if (mid_word.simple_ok) begin
                     res_valid      = 1'b1;
                     res.token_kind = mid_word.simple_kind;
                     res.argument   = {59'd0, mid_word.info};
                     phase_in       = PH_INITIAL;
                  end else begin
                     fail_go   = 1'b1;
                     fail_code = ERR_SIMPLE;
                  end
               end else if (mid_word.direct) begin
                  fin_go = 1'b1;
               end else begin
                  major_in = mid_word.major;
                  acc_in   = '0;
                  left_in  = mid_word.arg_len;
                  if (mid_word.message_end) begin
                     left_in   = '0;
                     fail_go   = 1'b1;
                     fail_code = ERR_HEAD_CUT;
                  end else begin
                     phase_in = PH_ARG;
                  end
               end
            end
            default: begin
               phase_in = PH_INITIAL;
            end
         endcase

         // complete head of major type 0..5
         if (fin_go) begin
            phase_in       = PH_INITIAL;
            res_valid      = 1'b1;
            res.token_kind = {1'b0, fin_major};
            res.argument   = fin_arg;
            unique case (fin_major)
               MAJ_UINT: begin
                  res.fits_signed  = !fin_arg[63];
                  res.signed_value = fin_arg[63] ? '0 : fin_arg;
               end
               MAJ_NEGINT: begin
                  res.fits_signed  = !fin_arg[63];
                  res.signed_value = fin_arg[63] ? '0 : ~fin_arg;
               end
               MAJ_BYTES, MAJ_TEXT: begin
                  if (fin_arg != 64'd0) begin
                     if (mid_word.message_end) begin
                        fail_go   = 1'b1;
                        fail_code = ERR_STR_CUT;
                     end else begin
                        pay_in   = fin_arg;
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
               default: begin
                  // array and map headers carry the count only
               end
            endcase
         end

         if (fail_go) begin
            res                = '0;
            res.token_kind     = KIND_ERROR;
            res.error_code     = fail_code;
            res.at_message_end = mid_word.message_end;
            res_valid          = 1'b1;
            phase_in           = mid_word.message_end ? PH_INITIAL : PH_DISCARD;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (wrote && !pop_ok) begin
         count_in = count_ff + 2'd1;
      end else if (!wrote && pop_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_INITIAL;
         major_ff  <= '0;
         left_ff   <= '0;
         acc_ff    <= '0;
         pay_ff    <= '0;
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         major_ff <= major_in;
         left_ff  <= left_in;
         acc_ff   <= acc_in;
         pay_ff   <= pay_in;
         count_ff <= count_in;
         if (wrote) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop_ok) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wrote) begin
         mem_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

FILE: design/cbor_stream_decoder.sv
// Streaming CBOR token decoder. Bytes of a message go in on the req_ queue, one
// word per byte, with message_end set on the final byte. Each complete head
// (integer, string header, array, map, false/true/null) comes out as one token
// word on the rsp_ queue, each string content byte as one payload word, and
// malformed input as one error word; after an error the rest of the message is
// dropped silently. Rate: one byte per cycle sustained while the result queue
// is not full, taken by the back-end state machine, which handles one byte per
// cycle. Each byte is classified into the front queue, then its result word is
// written to the result queue before it shows on rsp_. Both sides hold two
// words of buffering, so req_full only rises when the consumer stops popping.
module cbor_stream_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  cbor_sd_pkg::req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output cbor_sd_pkg::rsp_type rsp_data
);
   import cbor_sd_pkg::*;

`include "cbor_stream_decoder_macros.svh"

   // front-to-back queue head
   logic            mid_valid;
   cls_type         mid_word;
   back_status_type back_status;

   // front: splits each byte into major type / info and queues it
   cbor_sd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .mid_valid   (mid_valid),
      .mid_word    (mid_word),
      .back_status (back_status)
   );

   // back: phase machine, argument gathering, result queue
   cbor_sd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .mid_valid   (mid_valid),
      .mid_word    (mid_word),
      .back_status (back_status),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

   // back end only consumes words that exist
   `CSD_ASSERT_NOW(a_take_valid, back_status.take, mid_valid, "back took from empty queue")
   // a result only comes from a consumed byte
   `CSD_ASSERT_NOW(a_wrote_take, back_status.wrote, back_status.take, "result without byte")
   // result queue cannot fill by itself
   `CSD_ASSERT_NEXT(a_empty_hold, rsp_empty && !back_status.wrote, rsp_empty,
      "result appeared without a write")

endmodule
